// ----- rtl/core/svm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg
// shared types and constants of the sample voice mixer
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int SampleDepth = 65536;
    localparam int MaxVoices   = 16;
    localparam int SoundSlots  = 8;
    localparam int AddrW       = $clog2(SampleDepth);
    localparam int VoiceW      = $clog2(MaxVoices);
    localparam int CountW      = $clog2(MaxVoices + 1);
    localparam int SlotW       = $clog2(SoundSlots);

    localparam logic [15:0] UnityGain = 16'd4096;
    localparam logic [16:0] MaxLen    = 17'd65536;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_LOAD   = 3'd1,
        KIND_DEFINE = 3'd2,
        KIND_CTRL   = 3'd3,
        KIND_PLAY   = 3'd4,
        KIND_STOP   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        REG_MASTER_VOLUME = 2'd0,
        REG_MASTER_MUTE   = 2'd1,
        REG_MASTER_PAUSE  = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_MAC,
        ST_SCALE,
        ST_CLIP,
        ST_OUT
    } state_t;

    // per-voice step request from the sequencer to the voice table
    typedef struct packed {
        logic              start;
        logic [VoiceW-1:0] voice;
    } voice_req_t;

endpackage

// ----- rtl/core/svm_clip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_clip
// scales |t| (2^-39 units) to 32-bit full scale, truncated, saturated, signed
// ----------------------------------------------------------------------------
module svm_clip
    import svm_pkg::*;
(
    input  logic        neg,
    input  logic [51:0] mag_in,
    output logic [31:0] result
);
    logic [51:0] q;
    logic [7:0]  r;
    logic [39:0] rs;
    logic [31:0] m;

    always_comb
    begin
        q  = mag_in >> 8;
        r  = mag_in[7:0];
        rs = {1'b0, r, 31'd0};
        if (mag_in >= 52'h80_0000_0000)
        begin
            m = 32'h7FFF_FFFF;
        end
        else
        begin
            // floor(u*(2^31-1)/2^39) = (u>>8) - (r*2^31 < u)
            m = q[31:0] - ((52'(rs) < mag_in) ? 32'd1 : 32'd0);
        end
        result = neg ? (32'd0 - m) : m;
    end
endmodule

// ----- rtl/core/sample_voice_mixer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_mixer
// multi-voice sample playback mixer with a shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command word per item (kind in tuser, rest in tdata)
//   m_axis returns exactly one result word per command, in order
//   cfg_we/cfg_index/cfg_wdata write master volume, mute and pause
// sequencing
//   non-tick commands: accept moves the sequencer to its output state,
//   which then sets the held result register
//   tick: a walk, memory read and multiply-accumulate step per voice slot
//   for all 16 slots, then scale, clip and output; the single sample memory
//   read port and the shared multiply-accumulate set this sequence
//   a tick under master pause takes the non-tick path
//   one command is in flight at a time; s_axis_tready is low meanwhile
// reset
//   sounds cleared, gains unity, all voices free; sample memory undefined
//   no clearing pass, the block is ready right after reset
// stall
//   a result is held in the output register until m_axis_tready; a new
//   command is not taken until the held result has left
// ----------------------------------------------------------------------------
module sample_voice_mixer
    import svm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sound_id, address, sample_value, sound_length, volume, mute, pause,
    // loop_enable, zero pad
    input  logic [71:0] s_axis_tdata,
    // kind
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mixed_sample, play_rejected, active_voices, zero pad
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    // field unpack
    logic [2:0]  in_id;
    logic [15:0] in_addr;
    logic [15:0] in_sample;
    logic [16:0] in_len;
    logic [15:0] in_vol;
    logic        in_mute, in_pause, in_loop;
    assign in_id     = s_axis_tdata[2:0];
    assign in_addr   = s_axis_tdata[18:3];
    assign in_sample = s_axis_tdata[34:19];
    assign in_len    = s_axis_tdata[51:35];
    assign in_vol    = s_axis_tdata[67:52];
    assign in_mute   = s_axis_tdata[68];
    assign in_pause  = s_axis_tdata[69];
    assign in_loop   = s_axis_tdata[70];

    // master registers
    logic [15:0] mvol_reg;
    logic        mmute_reg, mpause_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvol_reg   <= UnityGain;
            mmute_reg  <= 1'b0;
            mpause_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MASTER_VOLUME: mvol_reg   <= cfg_wdata;
                REG_MASTER_MUTE:   mmute_reg  <= cfg_wdata[0];
                REG_MASTER_PAUSE:  mpause_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // sound table
    logic [15:0] snd_base_reg [SoundSlots];
    logic [16:0] snd_len_reg  [SoundSlots];
    logic [15:0] snd_gain_reg [SoundSlots];
    logic [2:0]  snd_flag_reg [SoundSlots];   // loop, pause, mute

    // voice table
    logic [MaxVoices-1:0] vvalid_reg;
    logic [SlotW-1:0]     vsound_reg [MaxVoices];
    logic [15:0]          vpos_reg   [MaxVoices];

    // sample memory, one write port and one read port
    logic [15:0] mem [SampleDepth];
    logic [15:0] rdata_reg;

    state_t      state_reg, state_next;
    voice_req_t  req;
    logic [VoiceW-1:0] vidx_reg;
    logic        last_voice;
    logic [2:0]  cur_s;
    logic        use_voice;
    logic        acc_en;
    logic signed [35:0] acc_reg;
    logic signed [52:0] prod_reg;
    logic [31:0] clip_res;
    logic        held_reg;
    logic [31:0] o_mix_reg;
    logic        o_rej_reg;
    logic        acc_go;
    logic        first_free_found;
    logic [VoiceW-1:0] first_free;

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !held_reg;
    assign last_voice = (vidx_reg == VoiceW'(MaxVoices - 1));
    assign cur_s = vsound_reg[vidx_reg];
    assign use_voice = vvalid_reg[vidx_reg] && !snd_flag_reg[cur_s][1];
    assign req.start = (state_reg == ST_MAC) && use_voice;
    assign req.voice = vidx_reg;

    always_comb
    begin
        first_free_found = 1'b0;
        first_free = '0;
        for (int v = MaxVoices - 1; v >= 0; v--)
        begin
            if (!vvalid_reg[v])
            begin
                first_free_found = 1'b1;
                first_free = VoiceW'(v);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (s_axis_tuser == KIND_TICK && !mpause_reg)
                        state_next = ST_WALK;
                    else
                        state_next = ST_OUT;
                end
            ST_WALK:  state_next = ST_READ;
            ST_READ:  state_next = ST_MAC;
            ST_MAC:   state_next = last_voice ? ST_SCALE : ST_WALK;
            ST_SCALE: state_next = ST_CLIP;
            ST_CLIP:  state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        acc_go = 1'b0;
        acc_en = 1'b0;
        unique case (state_reg)
            ST_MAC:  acc_en = use_voice && !mmute_reg && !snd_flag_reg[cur_s][0];
            ST_SCALE: acc_go = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // memory ports: load write, and voice read
    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == KIND_LOAD)
            mem[in_addr[AddrW-1:0]] <= in_sample;
        rdata_reg <= mem[AddrW'(snd_base_reg[cur_s] + vpos_reg[vidx_reg])];
    end

    // shared multiply-accumulate: sample x gain summed over voices, then sum x master volume
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
            acc_reg <= '0;
        else if (acc_en)
            acc_reg <= acc_reg + 36'(($signed(rdata_reg) * $signed({1'b0, snd_gain_reg[cur_s]})));
        if (acc_go)
            prod_reg <= acc_reg * $signed({1'b0, mvol_reg});
    end

    svm_clip u_clip (
        .neg    (prod_reg[52]),
        .mag_in (prod_reg[52] ? 52'(-prod_reg) : 52'(prod_reg)),
        .result (clip_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vidx_reg <= '0;
        else if (state_reg == ST_IDLE)
            vidx_reg <= '0;
        else if (state_reg == ST_MAC)
            vidx_reg <= vidx_reg + 1'b1;
    end

    // tables and voice updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vvalid_reg <= '0;
            for (int s = 0; s < SoundSlots; s++)
            begin
                snd_base_reg[s] <= '0;
                snd_len_reg[s]  <= '0;
                snd_gain_reg[s] <= UnityGain;
                snd_flag_reg[s] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                unique case (s_axis_tuser)
                    KIND_DEFINE:
                    begin
                        snd_base_reg[in_id] <= in_addr;
                        snd_len_reg[in_id]  <= (in_len > MaxLen) ? MaxLen : in_len;
                    end
                    KIND_CTRL:
                    begin
                        snd_gain_reg[in_id] <= in_vol;
                        snd_flag_reg[in_id] <= {in_loop, in_pause, in_mute};
                    end
                    KIND_PLAY:
                        if (snd_len_reg[in_id] != '0 && first_free_found)
                        begin
                            vvalid_reg[first_free] <= 1'b1;
                            vsound_reg[first_free] <= in_id;
                            vpos_reg[first_free]   <= '0;
                        end
                    KIND_STOP:
                        for (int v = 0; v < MaxVoices; v++)
                            if (vsound_reg[v] == in_id)
                                vvalid_reg[v] <= 1'b0;
                    default: ;
                endcase
            end
            if (req.start)
            begin
                if (17'(vpos_reg[req.voice]) + 17'd1 >= snd_len_reg[cur_s])
                begin
                    vpos_reg[req.voice] <= '0;
                    if (!snd_flag_reg[cur_s][2])
                        vvalid_reg[req.voice] <= 1'b0;
                end
                else
                    vpos_reg[req.voice] <= vpos_reg[req.voice] + 16'd1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            o_mix_reg <= '0;
            o_rej_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                o_mix_reg <= '0;
                o_rej_reg <= (s_axis_tuser == KIND_PLAY) &&
                             !(snd_len_reg[in_id] != '0 && first_free_found);
            end
            if (state_reg == ST_CLIP)
                o_mix_reg <= clip_res;
            if (state_reg == ST_OUT)
                held_reg <= 1'b1;
            else if (held_reg && m_axis_tready)
                held_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = held_reg;
    assign m_axis_tdata  = {2'b00, CountW'($countones(vvalid_reg)), o_rej_reg, o_mix_reg};
endmodule

// ----- rtl/core/svm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_checker
// port-level checks of the sample voice mixer
// ----------------------------------------------------------------------------
module svm_checker
    import svm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result held");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[36:33] == 4'd0 || m_axis_tdata[37:33] == 5'd16
            || m_axis_tdata[37] == 1'b0)
        else $error("voice count out of range");
    a_nontick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != KIND_TICK |=> ##1
            m_axis_tvalid && m_axis_tdata[31:0] == 32'd0)
        else $error("non-tick result not zero");
endmodule

bind sample_voice_mixer svm_checker u_svm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
